@@ src/ddo_pkg.sv @@
// odometry and gyro fusion package: payload structs, register indexes, op codes
// and the sine table generator; no dependencies
`default_nettype none

package ddo_pkg;

  typedef struct packed {
    logic               func;
    logic signed [15:0] left_count_delta;
    logic signed [15:0] right_count_delta;
    logic signed [15:0] gyro_raw;
    logic        [15:0] elapsed_ms;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [15:0] new_heading;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic               applied;
  } ddo_out_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_PER_DIFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_INIT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_SPEED    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_RATE      = 3'd7;

  localparam logic [23:0] RST_DIST_PER_COUNT = 24'd1000;
  localparam logic [23:0] RST_TURN_PER_DIFF  = 24'd701000;
  localparam logic [19:0] RST_GYRO_SCALE     = 20'd417;
  localparam logic [15:0] RST_BLEND_GAIN     = 16'd3277;
  localparam logic [15:0] RST_STILL_SPEED    = 16'd51;
  localparam logic [15:0] RST_BIAS_RATE      = 16'd66;

  // speed dividend: |count * dist_per_count| * 1000 / 256
  localparam int unsigned NUM_W = 41;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ML,
    OP_MR,
    OP_MT,
    OP_MGD,
    OP_MG,
    OP_MB,
    OP_ME,
    OP_MF,
    OP_RC,
    OP_RS,
    OP_MX,
    OP_AY,
    OP_COMMIT,
    OP_OUT
  } ddo_op_e;

  typedef struct packed {
    ddo_op_e op;
  } ddo_cmd_t;

  typedef struct packed {
    logic upd;
    logic gyro_en;
    logic div_done;
  } ddo_sts_t;

  // q30 sine of a 16-bit binary angle, taylor series to x^13
  function automatic logic signed [31:0] sine_q30(input logic [15:0] bau);
    logic [14:0] r;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    r = {1'b0, bau[13:0]};
    if (bau[14]) begin
      r = 15'h4000 - r;
    end
    x = (64'(r) * PI_Q30) >> 15;
    t = x;
    s = x;
    for (int k = 1; k <= 6; k++) begin
      t = (((t * x) >> 30) * x) >> 30;
      case (k)
        1: t = t / 64'd6;
        2: t = t / 64'd20;
        3: t = t / 64'd42;
        4: t = t / 64'd72;
        5: t = t / 64'd110;
        default: t = t / 64'd156;
      endcase
      if (k % 2 == 1) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    if (s > 64'h4000_0000) begin
      s = 64'h4000_0000;
    end
    return bau[15] ? -32'(s) : 32'(s);
  endfunction

endpackage

`default_nettype wire

@@ src/ddo_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned
// depends on ddo_pkg for the dividend width
`default_nettype none

module ddo_div #(
  parameter int unsigned DW = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ddo_pkg::NUM_W-1:0]  num_i,
  input  wire logic [DW-1:0]              den_i,
  output logic      [ddo_pkg::NUM_W-1:0]  quo_o,
  output logic                            done_o
);

  localparam int unsigned NW = ddo_pkg::NUM_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] acc_q, acc_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem_q, acc_q[NW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    acc_d = {acc_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ src/ddo_dpath.sv @@
// odometry datapath: config registers, pose state, shared multiplier,
// sine rom and two speed dividers; depends on ddo_pkg and ddo_div
`default_nettype none

module ddo_dpath #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned DT_MAX_MS       = 100
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ddo_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire ddo_pkg::ddo_in_t                  in_data_i,
  input  wire ddo_pkg::ddo_cmd_t                 cmd_i,
  output ddo_pkg::ddo_sts_t                      sts_o,
  output ddo_pkg::ddo_out_t                      out_data_o
);

  localparam int unsigned DTW    = $clog2(DT_MAX_MS + 1);
  localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
  localparam int unsigned SH     = 16 - SINE_TABLE_BITS;
  localparam int unsigned NW     = ddo_pkg::NUM_W;

  ddo_pkg::ddo_op_e op;

  // config
  logic [23:0] dpc_q;
  logic [23:0] tpc_q;
  logic [19:0] gs_q;
  logic        gen_q;
  logic [15:0] blend_q;
  logic [15:0] still_q;
  logic [15:0] rate_q;

  // pose state
  logic        [31:0] px_q;
  logic        [31:0] py_q;
  logic signed [15:0] hd_q;
  logic signed [23:0] bias_q;
  logic        [31:0] ls_q;
  logic        [31:0] rs_q;

  // working registers
  ddo_pkg::ddo_in_t   in_q;
  ddo_pkg::ddo_out_t  out_q;
  logic [DTW-1:0]     dt_q;
  logic               skip_q;
  logic signed [39:0] dl_q;
  logic signed [39:0] dr_q;
  logic signed [31:0] cen_q;
  logic signed [15:0] pred_q;
  logic signed [15:0] enc_q;
  logic signed [15:0] fused_q;
  logic signed [23:0] bnew_q;
  logic        [31:0] xn_q;
  logic        [31:0] yn_q;
  logic signed [31:0] rom_q;
  logic signed [63:0] p_q;

  logic signed [31:0] sine_rom [SINE_N];

  logic signed [16:0] diff;
  logic signed [24:0] gfull;
  logic signed [24:0] gdb;
  logic signed [15:0] err;
  logic signed [15:0] used;
  logic signed [15:0] mid;
  logic signed [15:0] cos_ang;
  logic signed [15:0] enc_d;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [31:0] a_s;
  logic signed [31:0] b_s;
  logic signed [63:0] mul_d;
  logic [DTW-1:0]     dt_c;
  logic [39:0]        abs_l;
  logic [39:0]        abs_r;
  logic [49:0]        n_l;
  logic [49:0]        n_r;
  logic [NW-1:0]      q_l;
  logic [NW-1:0]      q_r;
  logic               done_l;
  logic               done_r;
  logic               still;
  logic               div_go;

  for (genvar g = 0; g < SINE_N; g++) begin : g_rom
    assign sine_rom[g] = ddo_pkg::sine_q30(16'(g << SH));
  end

  function automatic logic [31:0] sat_speed(input logic neg, input logic [NW-1:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > NW'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[31:0];
    end else begin
      res = (mag > NW'(32'h8000_0000)) ? 32'h8000_0000 : -mag[31:0];
    end
    return res;
  endfunction

  assign op = cmd_i.op;

  always_comb begin
    diff    = 17'(in_q.right_count_delta) - 17'(in_q.left_count_delta);
    gfull   = (25'(in_q.gyro_raw) <<< 8) - 25'(bias_q);
    gdb     = (gfull > -25'sd512 && gfull < 25'sd512) ? '0 : gfull;
    err     = enc_q - pred_q;
    used    = fused_q - hd_q;
    mid     = hd_q + (used >>> 1);
    cos_ang = mid + 16'sh4000;
    enc_d   = hd_q + p_q[31:16];
    rom_addr = (op == ddo_pkg::OP_RC) ? cos_ang[15 -: SINE_TABLE_BITS]
                                      : mid[15 -: SINE_TABLE_BITS];
    dt_c  = (in_data_i.elapsed_ms > 16'(DT_MAX_MS)) ? DTW'(DT_MAX_MS)
                                                    : DTW'(in_data_i.elapsed_ms);
    abs_l = dl_q[39] ? 40'(-dl_q) : 40'(dl_q);
    abs_r = dr_q[39] ? 40'(-dr_q) : 40'(dr_q);
    // times 1000 as 1024 - 16 - 8
    n_l   = (50'(abs_l) << 10) - (50'(abs_l) << 4) - (50'(abs_l) << 3);
    n_r   = (50'(abs_r) << 10) - (50'(abs_r) << 4) - (50'(abs_r) << 3);
    still = (q_l < NW'(still_q)) && (q_r < NW'(still_q));
    div_go = (op == ddo_pkg::OP_MGD);
  end

  // shared multiplier operand select
  always_comb begin
    a_s = '0;
    b_s = '0;
    case (op)
      ddo_pkg::OP_ML: begin
        a_s = 32'(in_q.left_count_delta);
        b_s = 32'(dpc_q);
      end
      ddo_pkg::OP_MR: begin
        a_s = 32'(in_q.right_count_delta);
        b_s = 32'(dpc_q);
      end
      ddo_pkg::OP_MT: begin
        a_s = 32'(diff);
        b_s = 32'(tpc_q);
      end
      ddo_pkg::OP_MGD: begin
        a_s = 32'(gs_q);
        b_s = 32'(dt_q);
      end
      ddo_pkg::OP_MG: begin
        a_s = 32'(gdb);
        b_s = p_q[31:0];
      end
      ddo_pkg::OP_MB: begin
        a_s = 32'(gfull);
        b_s = 32'(rate_q);
      end
      ddo_pkg::OP_ME: begin
        a_s = 32'(err);
        b_s = 32'(blend_q);
      end
      ddo_pkg::OP_RS, ddo_pkg::OP_MX: begin
        a_s = cen_q;
        b_s = rom_q;
      end
      default: begin
        a_s = '0;
        b_s = '0;
      end
    endcase
  end

  assign mul_d = 64'(a_s) * 64'(b_s);

  ddo_div #(.DW(DTW)) u_div_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (n_l[48:8]),
    .den_i   (dt_q),
    .quo_o   (q_l),
    .done_o  (done_l)
  );

  ddo_div #(.DW(DTW)) u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (n_r[48:8]),
    .den_i   (dt_q),
    .quo_o   (q_r),
    .done_o  (done_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q   <= ddo_pkg::RST_DIST_PER_COUNT;
      tpc_q   <= ddo_pkg::RST_TURN_PER_DIFF;
      gs_q    <= ddo_pkg::RST_GYRO_SCALE;
      gen_q   <= 1'b0;
      blend_q <= ddo_pkg::RST_BLEND_GAIN;
      still_q <= ddo_pkg::RST_STILL_SPEED;
      rate_q  <= ddo_pkg::RST_BIAS_RATE;
      px_q    <= '0;
      py_q    <= '0;
      hd_q    <= '0;
      bias_q  <= '0;
      ls_q    <= '0;
      rs_q    <= '0;
    end else begin
      if (op == ddo_pkg::OP_COMMIT) begin
        if (in_q.func) begin
          px_q <= in_q.new_x;
          py_q <= in_q.new_y;
          hd_q <= in_q.new_heading;
          ls_q <= '0;
          rs_q <= '0;
        end else if (!skip_q) begin
          px_q <= xn_q;
          py_q <= yn_q;
          hd_q <= fused_q;
          ls_q <= sat_speed(dl_q[39], q_l);
          rs_q <= sat_speed(dr_q[39], q_r);
          if (gen_q && still) begin
            bias_q <= bnew_q;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ddo_pkg::CFG_DIST_PER_COUNT: dpc_q   <= cfg_wdata_i;
          ddo_pkg::CFG_TURN_PER_DIFF:  tpc_q   <= cfg_wdata_i;
          ddo_pkg::CFG_GYRO_SCALE:     gs_q    <= cfg_wdata_i[19:0];
          ddo_pkg::CFG_GYRO_ENABLE:    gen_q   <= cfg_wdata_i[0];
          ddo_pkg::CFG_BLEND_GAIN:     blend_q <= cfg_wdata_i[15:0];
          ddo_pkg::CFG_BIAS_INIT:      bias_q  <= cfg_wdata_i;
          ddo_pkg::CFG_STILL_SPEED:    still_q <= cfg_wdata_i[15:0];
          ddo_pkg::CFG_BIAS_RATE:      rate_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= mul_d;
    rom_q <= sine_rom[rom_addr];
    case (op)
      ddo_pkg::OP_LOAD: begin
        in_q   <= in_data_i;
        dt_q   <= dt_c;
        skip_q <= !in_data_i.func && (in_data_i.elapsed_ms == '0);
      end
      ddo_pkg::OP_MR: dl_q <= p_q[39:0];
      ddo_pkg::OP_MT: dr_q <= p_q[39:0];
      ddo_pkg::OP_MGD: begin
        enc_q   <= enc_d;
        fused_q <= enc_d;
        cen_q   <= 32'((41'(dl_q) + 41'(dr_q)) >>> 9);
      end
      ddo_pkg::OP_MB: pred_q <= hd_q + p_q[39:24];
      ddo_pkg::OP_ME: bnew_q <= bias_q + p_q[39:16];
      ddo_pkg::OP_MF: fused_q <= pred_q + p_q[31:16];
      ddo_pkg::OP_MX: xn_q <= px_q + p_q[61:30];
      ddo_pkg::OP_AY: yn_q <= py_q + p_q[61:30];
      ddo_pkg::OP_OUT: begin
        out_q.pos_x       <= px_q;
        out_q.pos_y       <= py_q;
        out_q.heading     <= hd_q;
        out_q.left_speed  <= ls_q;
        out_q.right_speed <= rs_q;
        out_q.applied     <= !skip_q;
      end
      default: ;
    endcase
  end

  assign sts_o.upd      = !in_data_i.func && (in_data_i.elapsed_ms != '0);
  assign sts_o.gyro_en  = gen_q;
  assign sts_o.div_done = done_l && done_r;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

@@ src/ddo_ctrl.sv @@
// odometry controller: one-hot sequencer stepping the datapath through an update
// and owning the channel handshakes; depends on ddo_pkg
`default_nettype none

module ddo_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire ddo_pkg::ddo_sts_t  sts_i,
  output ddo_pkg::ddo_cmd_t       cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_ML   = 16'h0002,
    S_MR   = 16'h0004,
    S_MT   = 16'h0008,
    S_MGD  = 16'h0010,
    S_MG   = 16'h0020,
    S_MB   = 16'h0040,
    S_ME   = 16'h0080,
    S_MF   = 16'h0100,
    S_RC   = 16'h0200,
    S_RS   = 16'h0400,
    S_MX   = 16'h0800,
    S_AY   = 16'h1000,
    S_DIV  = 16'h2000,
    S_FIN  = 16'h4000,
    S_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   free;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = ddo_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = ddo_pkg::OP_LOAD;
          state_d  = sts_i.upd ? S_ML : S_FIN;
        end
      end
      S_ML: begin
        cmd_o.op = ddo_pkg::OP_ML;
        state_d  = S_MR;
      end
      S_MR: begin
        cmd_o.op = ddo_pkg::OP_MR;
        state_d  = S_MT;
      end
      S_MT: begin
        cmd_o.op = ddo_pkg::OP_MT;
        state_d  = S_MGD;
      end
      S_MGD: begin
        cmd_o.op = ddo_pkg::OP_MGD;
        state_d  = sts_i.gyro_en ? S_MG : S_RC;
      end
      S_MG: begin
        cmd_o.op = ddo_pkg::OP_MG;
        state_d  = S_MB;
      end
      S_MB: begin
        cmd_o.op = ddo_pkg::OP_MB;
        state_d  = S_ME;
      end
      S_ME: begin
        cmd_o.op = ddo_pkg::OP_ME;
        state_d  = S_MF;
      end
      S_MF: begin
        cmd_o.op = ddo_pkg::OP_MF;
        state_d  = S_RC;
      end
      S_RC: begin
        cmd_o.op = ddo_pkg::OP_RC;
        state_d  = S_RS;
      end
      S_RS: begin
        cmd_o.op = ddo_pkg::OP_RS;
        state_d  = S_MX;
      end
      S_MX: begin
        cmd_o.op = ddo_pkg::OP_MX;
        state_d  = S_AY;
      end
      S_AY: begin
        cmd_o.op = ddo_pkg::OP_AY;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = ddo_pkg::OP_COMMIT;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (free) begin
          cmd_o.op = ddo_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_OUT && free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start work");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && free) |=> out_valid_q)
    else $error("result not presented after load");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output step");

endmodule

`default_nettype wire

@@ src/diff_drive_odometry_gyro_fusion.sv @@
// differential drive odometry with yaw gyro fusion, top level
// depends on ddo_pkg, ddo_ctrl, ddo_dpath, ddo_div
//
// channel   direction  signals                                   payload
// config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i           register write
// request   in         in_valid_i, in_stall_o, in_data_i         ddo_pkg::ddo_in_t
// result    out        out_valid_o, out_stall_i, out_data_o      ddo_pkg::ddo_out_t
//
// for an update request the result waits on the two bit-serial speed dividers
// (ddo_pkg::NUM_W quotient bits), started after the wheel travel products
// set pose and zero elapsed time requests skip straight to commit and output
// one request at a time; the result register holds while the sink stalls
// reset loads the register defaults and zeroes the pose and speeds
`default_nettype none

module diff_drive_odometry_gyro_fusion #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned DT_MAX_MS       = 100
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ddo_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire ddo_pkg::ddo_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output ddo_pkg::ddo_out_t                   out_data_o
);

  ddo_pkg::ddo_cmd_t cmd;
  ddo_pkg::ddo_sts_t sts;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddo_dpath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .DT_MAX_MS       (DT_MAX_MS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
